// ----- rtl/core/dls_pkg.sv -----
package dls_pkg;

   // sizing of the line counters and the line tally
   localparam int MAX_LINE_CHARS = 4096;
   localparam int CHECK_LINES    = 5;
   localparam int NCAND          = 4;
   localparam int CNT_W          = $clog2(MAX_LINE_CHARS + 1);
   localparam int LINE_W         = $clog2(CHECK_LINES + 1);
   localparam int SCORE_W        = 16;
   localparam int RAW_W          = CNT_W + LINE_W + 2;
   localparam int CAND_W         = $clog2(NCAND);

   // fixed payload widths
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int DELIM_W  = 3;
   localparam int USED_W   = 3;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [DELIM_W-1:0]  delim_type;
   typedef logic [CNT_W-1:0]    count_type;
   typedef logic [LINE_W-1:0]   line_type;
   typedef logic [SCORE_W-1:0]  score_type;

   typedef logic [NCAND-1:0][CNT_W-1:0]  count_arr_type;
   typedef logic [NCAND-1:0][LINE_W-1:0] line_arr_type;

   // action codes; the spare code is ignored
   localparam action_type ACT_CHAR   = 2'd0;
   localparam action_type ACT_EOL    = 2'd1;
   localparam action_type ACT_EOS    = 2'd2;
   localparam action_type ACT_IGNORE = 2'd3;

   // reported delimiter codes
   localparam delim_type DLM_UNKNOWN = 3'd0;
   localparam delim_type DLM_COMMA   = 3'd1;
   localparam delim_type DLM_SEMI    = 3'd2;
   localparam delim_type DLM_TAB     = 3'd3;
   localparam delim_type DLM_SPACE   = 3'd4;

   // candidate slots, in tie-break order
   localparam int SLOT_TAB   = 0;
   localparam int SLOT_SPACE = 1;
   localparam int SLOT_COMMA = 2;
   localparam int SLOT_SEMI  = 3;

   localparam char_type  CAND_CHAR [NCAND] = '{8'h09, 8'h20, 8'h2C, 8'h3B};
   localparam delim_type CAND_CODE [NCAND] = '{DLM_TAB, DLM_SPACE, DLM_COMMA, DLM_SEMI};

   typedef struct packed {
      delim_type delimiter;
      score_type best_score;
      logic [USED_W-1:0] lines_used;
   } result_type;

endpackage

// ----- rtl/core/dls_req_if.sv -----
interface dls_req_if;
   logic                 valid;
   logic                 ready;
   dls_pkg::action_type  action;
   dls_pkg::char_type    character;

   modport source (output valid, action, character, input ready);
   modport sink   (input valid, action, character, output ready);
endinterface

// ----- rtl/core/dls_rsp_if.sv -----
interface dls_rsp_if;
   logic                                valid;
   logic                                ready;
   dls_pkg::delim_type                  delimiter;
   dls_pkg::score_type                  best_score;
   logic [dls_pkg::USED_W-1:0]          lines_used;

   modport source (output valid, delimiter, best_score, lines_used, input ready);
   modport sink   (input valid, delimiter, best_score, lines_used, output ready);
endinterface

// ----- rtl/core/delimiter_sniffer.sv -----
// an end-of-sample item passes the input register and then the result register to reach rsp_chan
// throughput: one item per cycle; an input register feeds a single update stage
// only an end-of-sample item waits, and only while the previous result is untaken
// synchronous active-high reset clears all counters and the input and result valid flags
module delimiter_sniffer (
   input  logic           clock,
   input  logic           reset,
   dls_req_if.sink        req_chan,
   dls_rsp_if.source      rsp_chan
);

   logic                    s1_valid_ff, s1_valid_in;
   dls_pkg::action_type     s1_action_ff;
   dls_pkg::char_type       s1_char_ff;

   dls_pkg::count_arr_type  line_cnt_ff, line_cnt_in;
   dls_pkg::count_arr_type  first_cnt_ff, first_cnt_in;
   dls_pkg::line_arr_type   match_ff, match_in;
   dls_pkg::line_type       lines_ff, lines_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   dls_pkg::result_type     rsp_ff, rsp_in;
   dls_pkg::result_type     score_res;

   logic                    advance;
   logic                    req_xfer;
   logic                    is_eos;

   // stage one moves on unless it holds end of sample and the result is still waiting
   assign is_eos         = (s1_action_ff == dls_pkg::ACT_EOS);
   assign advance        = s1_valid_ff && (!is_eos || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   dls_score u_score (
      .first_counts (first_cnt_ff),
      .matching     (match_ff),
      .lines_seen   (lines_ff),
      .result       (score_res)
   );

   // counter update for the item in stage one
   always_comb begin
      line_cnt_in  = line_cnt_ff;
      first_cnt_in = first_cnt_ff;
      match_in     = match_ff;
      lines_in     = lines_ff;
      if (advance) begin
         case (s1_action_ff)
            dls_pkg::ACT_CHAR: begin
               for (int i = 0; i < dls_pkg::NCAND; i++) begin
                  if (s1_char_ff == dls_pkg::CAND_CHAR[i] &&
                      line_cnt_ff[i] < dls_pkg::CNT_W'(dls_pkg::MAX_LINE_CHARS)) begin
                     line_cnt_in[i] = line_cnt_ff[i] + 1'b1;
                  end
               end
            end
            dls_pkg::ACT_EOL: begin
               for (int i = 0; i < dls_pkg::NCAND; i++) begin
                  if (lines_ff == '0) begin
                     first_cnt_in[i] = line_cnt_ff[i];
                     match_in[i]     = dls_pkg::LINE_W'(1);
                  end else if (lines_ff < dls_pkg::LINE_W'(dls_pkg::CHECK_LINES)) begin
                     if (line_cnt_ff[i] == first_cnt_ff[i]) begin
                        match_in[i] = match_ff[i] + 1'b1;
                     end
                  end
                  line_cnt_in[i] = '0;
               end
               if (lines_ff < dls_pkg::LINE_W'(dls_pkg::CHECK_LINES)) begin
                  lines_in = lines_ff + 1'b1;
               end
            end
            dls_pkg::ACT_EOS: begin
               line_cnt_in  = '0;
               first_cnt_in = '0;
               match_in     = '0;
               lines_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // result register loads on end of sample, drops after its transfer
   always_comb begin
      rsp_in = rsp_ff;
      if (advance && is_eos) begin
         rsp_valid_in = 1'b1;
         rsp_in       = score_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         line_cnt_ff  <= '0;
         first_cnt_ff <= '0;
         match_ff     <= '0;
         lines_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         line_cnt_ff  <= line_cnt_in;
         first_cnt_ff <= first_cnt_in;
         match_ff     <= match_in;
         lines_ff     <= lines_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_action_ff <= req_chan.action;
         s1_char_ff   <= req_chan.character;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.delimiter  = rsp_ff.delimiter;
   assign rsp_chan.best_score = rsp_ff.best_score;
   assign rsp_chan.lines_used = rsp_ff.lines_used;

endmodule

// ----- rtl/core/dls_score.sv -----
module dls_score (
   input  dls_pkg::count_arr_type first_counts,
   input  dls_pkg::line_arr_type  matching,
   input  dls_pkg::line_type      lines_seen,
   output dls_pkg::result_type    result
);

   logic [dls_pkg::RAW_W-1:0]    raw   [dls_pkg::NCAND];
   logic [dls_pkg::RAW_W-1:0]    prod  [dls_pkg::NCAND];
   dls_pkg::score_type           sat   [dls_pkg::NCAND];
   dls_pkg::score_type           best;
   logic [dls_pkg::CAND_W-1:0]   win;

   // per-candidate score with priority scaling, saturated to the output width
   always_comb begin
      for (int i = 0; i < dls_pkg::NCAND; i++) begin
         prod[i] = dls_pkg::RAW_W'(first_counts[i]) * dls_pkg::RAW_W'(matching[i]);
         if (i == dls_pkg::SLOT_TAB) begin
            raw[i] = prod[i] << 1;
         end else if (i == dls_pkg::SLOT_SEMI) begin
            raw[i] = (prod[i] + (prod[i] << 1)) >> 1;
         end else begin
            raw[i] = prod[i];
         end
         if (raw[i] > dls_pkg::RAW_W'({dls_pkg::SCORE_W{1'b1}})) begin
            sat[i] = '1;
         end else begin
            sat[i] = raw[i][dls_pkg::SCORE_W-1:0];
         end
      end
   end

   // strictly greater wins, so ties stay with the earlier candidate
   always_comb begin
      best = sat[0];
      win  = '0;
      for (int i = 1; i < dls_pkg::NCAND; i++) begin
         if (sat[i] > best) begin
            best = sat[i];
            win  = dls_pkg::CAND_W'(i);
         end
      end
   end

   // no ended line gives an unknown delimiter
   always_comb begin
      result.lines_used = dls_pkg::USED_W'(lines_seen);
      if (lines_seen == '0) begin
         result.delimiter  = dls_pkg::DLM_UNKNOWN;
         result.best_score = '0;
      end else begin
         result.delimiter  = dls_pkg::CAND_CODE[win];
         result.best_score = best;
      end
   end

endmodule

// ----- rtl/core/dls_checker.sv -----
module dls_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input dls_pkg::delim_type         rsp_delimiter,
   input dls_pkg::score_type         rsp_best_score,
   input logic [dls_pkg::USED_W-1:0] rsp_lines_used
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // nothing is offered straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // unknown delimiter only with no lines, and then a zero score
   a_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_lines_used == '0) |->
         (rsp_delimiter == dls_pkg::DLM_UNKNOWN) && (rsp_best_score == '0))
      else $error("result with no lines is not unknown");

   // any counted line names a real delimiter within the scored window
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_lines_used != '0) |->
         (rsp_delimiter != dls_pkg::DLM_UNKNOWN) &&
         (rsp_lines_used <= dls_pkg::USED_W'(dls_pkg::CHECK_LINES)))
      else $error("result with lines has bad delimiter or line count");

endmodule

bind delimiter_sniffer dls_checker u_dls_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_delimiter  (rsp_chan.delimiter),
   .rsp_best_score (rsp_chan.best_score),
   .rsp_lines_used (rsp_chan.lines_used)
);
